FILE: hw/rtl/lfps_pkg.sv
package lfps_pkg;

  localparam int GAIN_W    = 20;
  localparam int INTEG_W   = 16;
  localparam int OUT_W     = 13;
  localparam int MAC_TERMS = 3;
  localparam int ADDR_W    = 5;
  localparam int REG_IDX_W = 3;

  localparam logic [1:0] MODE_RUN  = 2'd0;
  localparam logic [1:0] MODE_STOP = 2'd1;

  localparam logic [REG_IDX_W-1:0] REG_BASE_DRIVE   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_P       = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_I       = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_D       = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_FILTER_ALPHA = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_INTEG_LIMIT  = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_STEER_LIMIT  = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_DRIVE_LIMIT  = 3'd7;

  typedef struct packed {
    logic [11:0]              base_drive;
    logic signed [GAIN_W-1:0] gain_p;
    logic signed [GAIN_W-1:0] gain_i;
    logic signed [GAIN_W-1:0] gain_d;
    logic [8:0]               filter_alpha;
    logic [14:0]              integral_limit;
    logic [14:0]              steer_limit;
    logic [11:0]              drive_limit;
  } cfg_t;

  localparam cfg_t CFG_RST = '{
    base_drive:     12'd800,
    gain_p:         -20'sd25600,
    gain_i:         -20'sd128,
    gain_d:         -20'sd166,
    filter_alpha:   9'd179,
    integral_limit: 15'd300,
    steer_limit:    15'd200,
    drive_limit:    12'd4095
  };

endpackage

FILE: hw/rtl/lfps_regs.sv
module lfps_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [lfps_pkg::ADDR_W-1:0]  cfg_paddr,
  input  logic [31:0]                  cfg_pwdata,
  output logic [31:0]                  cfg_prdata,
  output logic                         cfg_pready,
  output lfps_pkg::cfg_t               cfg
);

  lfps_pkg::cfg_t                     cfg_r;
  logic [lfps_pkg::REG_IDX_W-1:0]     idx;
  logic                               wr;

  assign idx        = cfg_paddr[lfps_pkg::ADDR_W-1:2];
  assign wr         = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= lfps_pkg::CFG_RST;
    end else if (wr) begin
      case (idx)
        lfps_pkg::REG_BASE_DRIVE:   cfg_r.base_drive     <= cfg_pwdata[11:0];
        lfps_pkg::REG_GAIN_P:       cfg_r.gain_p         <= cfg_pwdata[19:0];
        lfps_pkg::REG_GAIN_I:       cfg_r.gain_i         <= cfg_pwdata[19:0];
        lfps_pkg::REG_GAIN_D:       cfg_r.gain_d         <= cfg_pwdata[19:0];
        lfps_pkg::REG_FILTER_ALPHA: cfg_r.filter_alpha   <= cfg_pwdata[8:0];
        lfps_pkg::REG_INTEG_LIMIT:  cfg_r.integral_limit <= cfg_pwdata[14:0];
        lfps_pkg::REG_STEER_LIMIT:  cfg_r.steer_limit    <= cfg_pwdata[14:0];
        lfps_pkg::REG_DRIVE_LIMIT:  cfg_r.drive_limit    <= cfg_pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      lfps_pkg::REG_BASE_DRIVE:   cfg_prdata = {20'b0, cfg_r.base_drive};
      lfps_pkg::REG_GAIN_P:       cfg_prdata = {12'b0, cfg_r.gain_p};
      lfps_pkg::REG_GAIN_I:       cfg_prdata = {12'b0, cfg_r.gain_i};
      lfps_pkg::REG_GAIN_D:       cfg_prdata = {12'b0, cfg_r.gain_d};
      lfps_pkg::REG_FILTER_ALPHA: cfg_prdata = {23'b0, cfg_r.filter_alpha};
      lfps_pkg::REG_INTEG_LIMIT:  cfg_prdata = {17'b0, cfg_r.integral_limit};
      lfps_pkg::REG_STEER_LIMIT:  cfg_prdata = {17'b0, cfg_r.steer_limit};
      lfps_pkg::REG_DRIVE_LIMIT:  cfg_prdata = {20'b0, cfg_r.drive_limit};
      default:                    cfg_prdata = 32'b0;
    endcase
  end

endmodule

FILE: hw/rtl/lfps_smac.sv
// Bit-serial sum of three signed products. One multiplier bit per cycle, LSB
// first; the top bit carries negative weight. Partial sum shifts right into lo.
module lfps_smac #(
  parameter int MC_W = 20,
  parameter int MP_W = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic signed [MC_W-1:0]        mcand  [lfps_pkg::MAC_TERMS],
  input  logic [MP_W-1:0]               mplier [lfps_pkg::MAC_TERMS],
  output logic                          done,
  output logic signed [MC_W+MP_W+2:0]   prod
);

  localparam int HW = MC_W + 3;
  localparam int CW = $clog2(MP_W);

  logic signed [MC_W-1:0] mc_r [lfps_pkg::MAC_TERMS];
  logic [MP_W-1:0]        mp_r [lfps_pkg::MAC_TERMS];
  logic signed [HW-1:0]   hi_r;
  logic signed [HW-1:0]   hi_nxt;
  logic signed [HW-1:0]   acc;
  logic [MP_W-1:0]        lo_r;
  logic [CW-1:0]          cnt_r;
  logic                   busy_r;
  logic                   done_r;
  logic                   last;

  always_comb begin
    last = (cnt_r == CW'(MP_W - 1));
    acc  = hi_r;
    for (int i = 0; i < lfps_pkg::MAC_TERMS; i++) begin
      if (mp_r[i][0]) begin
        if (last) begin
          acc = acc - HW'(mc_r[i]);
        end else begin
          acc = acc + HW'(mc_r[i]);
        end
      end
    end
    hi_nxt = acc >>> 1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && last;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && last) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mc_r  <= mcand;
      mp_r  <= mplier;
      hi_r  <= '0;
      cnt_r <= '0;
    end else if (busy_r) begin
      hi_r  <= hi_nxt;
      lo_r  <= {acc[0], lo_r[MP_W-1:1]};
      cnt_r <= cnt_r + CW'(1);
      for (int i = 0; i < lfps_pkg::MAC_TERMS; i++) begin
        mp_r[i] <= mp_r[i] >> 1;
      end
    end
  end

  assign done = done_r;
  assign prod = $signed({hi_r, lo_r});

endmodule

FILE: hw/rtl/line_follow_pid_steering.sv
// Run word: the result follows the two bit-serial multiply-accumulate passes (filter,
// then PID dot product), the steer clamp and the drive mix.
// Stop word: a zero drive result is loaded via ST_OUT. Other modes: no result.
// One word in flight; in_tready returns as the result is loaded into the output register.
// Synchronous active-low reset clears control, filter and integral state and
// loads register defaults.
module line_follow_pid_steering #(
  parameter int OFFSET_BITS = 10,
  parameter int FRAC_BITS   = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [((OFFSET_BITS+7)/8)*8-1:0]  in_tdata,  // line_offset
  input  logic [1:0]                        in_tuser,  // mode
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [31:0]                       out_tdata, // left_drive, right_drive
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [lfps_pkg::ADDR_W-1:0]       cfg_paddr,
  input  logic [31:0]                       cfg_pwdata,
  output logic [31:0]                       cfg_prdata,
  output logic                              cfg_pready
);

  localparam int OB    = OFFSET_BITS;
  localparam int FB    = FRAC_BITS;
  localparam int IW    = lfps_pkg::INTEG_W;
  localparam int GW    = lfps_pkg::GAIN_W;
  localparam int OW    = lfps_pkg::OUT_W;
  localparam int MCF_W = OB + 1;
  localparam int MPF_W = FB + 2;
  localparam int PF_W  = MCF_W + MPF_W + 3;
  localparam int ISW   = ((OB + 1 > IW) ? OB + 1 : IW) + 1;
  localparam int MB    = (OB + 2 > IW) ? OB + 2 : IW;
  localparam int PD_W  = GW + MB + 3;
  localparam int QW    = PD_W - FB;
  localparam int AW    = (FB + 1 > 9) ? FB + 1 : 9;
  localparam int SMW   = 18;
  localparam int STW   = 16;
  localparam logic [AW-1:0] ONE_A = AW'(1) << FB;
  localparam logic [FB:0]   ONE_F = (FB + 1)'(1) << FB;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_FILT  = 7'b0000010,
    ST_INTG  = 7'b0000100,
    ST_DOT   = 7'b0001000,
    ST_STEER = 7'b0010000,
    ST_MIX   = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_t;

  lfps_pkg::cfg_t cfg;

  state_t state_r, state_nxt;

  logic                  accept, run_go, stop_go;
  logic signed [OB-1:0]  in_off;
  logic [OB-1:0]         e_abs;
  logic                  pos_r;
  logic [AW-1:0]         alpha_x;
  logic [FB:0]           a_sat;
  logic [FB:0]           na;

  logic signed [MCF_W-1:0] mcand_f  [lfps_pkg::MAC_TERMS];
  logic [MPF_W-1:0]        mplier_f [lfps_pkg::MAC_TERMS];
  logic                    done_f;
  logic signed [PF_W-1:0]  prod_f;

  logic signed [GW-1:0]    mcand_d  [lfps_pkg::MAC_TERMS];
  logic [MB-1:0]           mplier_d [lfps_pkg::MAC_TERMS];
  logic                    done_d;
  logic signed [PD_W-1:0]  prod_d;

  logic [OB-1:0]           f_r, fp_r;
  logic signed [IW-1:0]    integ_r, integ_nxt;
  logic signed [ISW-1:0]   isum, ilim;
  logic signed [OB:0]      dif;
  logic signed [PD_W-1:0]  sum_r;
  logic signed [QW-1:0]    q, slim;
  logic signed [STW-1:0]   steer_r, steer_nxt;
  logic signed [SMW-1:0]   base_m, st_m, plus_m, minus_m, l_raw, r_raw, dlim;
  logic signed [OW-1:0]    left_r, right_r, left_nxt, right_nxt;
  logic                    out_tvalid_r;
  logic [31:0]             out_tdata_r;

  lfps_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign run_go    = accept && (in_tuser == lfps_pkg::MODE_RUN);
  assign stop_go   = accept && (in_tuser == lfps_pkg::MODE_STOP);
  assign in_off    = in_tdata[OB-1:0];
  assign e_abs     = in_off[OB-1] ? OB'(-in_off) : OB'(in_off);

  // saturate alpha at one
  assign alpha_x = AW'(cfg.filter_alpha);
  assign a_sat   = (alpha_x > ONE_A) ? ONE_A[FB:0] : alpha_x[FB:0];
  assign na      = ONE_F - a_sat;

  assign mcand_f[0]  = $signed({1'b0, e_abs});
  assign mcand_f[1]  = $signed({1'b0, fp_r});
  assign mcand_f[2]  = '0;
  assign mplier_f[0] = MPF_W'(na);
  assign mplier_f[1] = MPF_W'(a_sat);
  assign mplier_f[2] = '0;

  lfps_smac #(.MC_W(MCF_W), .MP_W(MPF_W)) u_filt (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (run_go),
    .mcand  (mcand_f),
    .mplier (mplier_f),
    .done   (done_f),
    .prod   (prod_f)
  );

  // integral clamp and derivative term
  always_comb begin
    isum = ISW'(integ_r) + ISW'({1'b0, f_r});
    ilim = ISW'($signed({1'b0, cfg.integral_limit}));
    if (isum > ilim) begin
      integ_nxt = IW'(ilim);
    end else if (isum < -ilim) begin
      integ_nxt = IW'(-ilim);
    end else begin
      integ_nxt = IW'(isum);
    end
    dif = $signed({1'b0, f_r}) - $signed({1'b0, fp_r});
  end

  assign mcand_d[0]  = cfg.gain_p;
  assign mcand_d[1]  = cfg.gain_i;
  assign mcand_d[2]  = cfg.gain_d;
  assign mplier_d[0] = MB'({1'b0, f_r});
  assign mplier_d[1] = MB'(integ_nxt);
  assign mplier_d[2] = MB'(dif);

  lfps_smac #(.MC_W(GW), .MP_W(MB)) u_dot (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (state_r == ST_INTG),
    .mcand  (mcand_d),
    .mplier (mplier_d),
    .done   (done_d),
    .prod   (prod_d)
  );

  // drop fraction toward zero, then clamp the correction
  always_comb begin
    q = QW'(sum_r >>> FB);
    if (sum_r[PD_W-1] && (|sum_r[FB-1:0])) begin
      q = q + QW'(1);
    end
    slim = QW'($signed({1'b0, cfg.steer_limit}));
    if (q > slim) begin
      steer_nxt = STW'(slim);
    end else if (q < -slim) begin
      steer_nxt = STW'(-slim);
    end else begin
      steer_nxt = STW'(q);
    end
  end

  always_comb begin
    base_m  = SMW'($signed({1'b0, cfg.base_drive}));
    st_m    = SMW'(steer_r);
    plus_m  = base_m + st_m;
    minus_m = base_m - st_m;
    dlim    = SMW'($signed({1'b0, cfg.drive_limit}));
    l_raw   = pos_r ? minus_m : plus_m;
    r_raw   = pos_r ? plus_m : minus_m;
    if (l_raw > dlim) begin
      left_nxt = OW'(dlim);
    end else if (l_raw < -dlim) begin
      left_nxt = OW'(-dlim);
    end else begin
      left_nxt = OW'(l_raw);
    end
    if (r_raw > dlim) begin
      right_nxt = OW'(dlim);
    end else if (r_raw < -dlim) begin
      right_nxt = OW'(-dlim);
    end else begin
      right_nxt = OW'(r_raw);
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (run_go) begin
          state_nxt = ST_FILT;
        end else if (stop_go) begin
          state_nxt = ST_OUT;
        end
      end
      ST_FILT:  if (done_f) state_nxt = ST_INTG;
      ST_INTG:  state_nxt = ST_DOT;
      ST_DOT:   if (done_d) state_nxt = ST_STEER;
      ST_STEER: state_nxt = ST_MIX;
      ST_MIX:   state_nxt = ST_OUT;
      ST_OUT:   if (!out_tvalid_r || out_tready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
      fp_r         <= '0;
      integ_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_INTG) begin
        integ_r <= integ_nxt;
        fp_r    <= f_r;
      end
      if (state_r == ST_OUT && (!out_tvalid_r || out_tready)) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (run_go) begin
      pos_r <= !in_off[OB-1] && (|in_off);
    end
    if (stop_go) begin
      left_r  <= '0;
      right_r <= '0;
    end else if (state_r == ST_MIX) begin
      left_r  <= left_nxt;
      right_r <= right_nxt;
    end
    if (state_r == ST_FILT && done_f) begin
      f_r <= prod_f[FB +: OB];
    end
    if (state_r == ST_DOT && done_d) begin
      sum_r <= prod_d;
    end
    if (state_r == ST_STEER) begin
      steer_r <= steer_nxt;
    end
    if (state_r == ST_OUT && (!out_tvalid_r || out_tready)) begin
      out_tdata_r <= {6'b0, right_r, left_r};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

FILE: hw/rtl/lfps_chk.sv
module lfps_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic [1:0]                        in_tuser,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [31:0]                       out_tdata
);

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  a_busy_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready &&
    (in_tuser == lfps_pkg::MODE_RUN || in_tuser == lfps_pkg::MODE_STOP)
    |=> !in_tready)
    else $error("input taken while a word is in progress");

  a_idle_after_noop: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready &&
    in_tuser != lfps_pkg::MODE_RUN && in_tuser != lfps_pkg::MODE_STOP
    |=> in_tready)
    else $error("no-action word left the block busy");

  a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[12:0] != 13'h1000 && out_tdata[25:13] != 13'h1000
                   && out_tdata[31:26] == 6'b0)
    else $error("drive outside clamp range");

endmodule

bind line_follow_pid_steering lfps_chk u_lfps_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
